/* hdl/ccsd_pkg.sv */
// Shared types, constants and digit helpers for the calendar clock display.
package ccsd_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // Register indexes on the configuration port
  localparam cfg_index_t CFG_DISPLAY_ENABLE   = 8'd0;
  localparam cfg_index_t CFG_TICKS_PER_SECOND = 8'd1;
  localparam cfg_index_t CFG_MIN_PRESS_TICKS  = 8'd2;
  localparam cfg_index_t CFG_MAX_PRESS_TICKS  = 8'd3;

  // Display modes
  localparam logic [1:0] MODE_TIME       = 2'd0;
  localparam logic [1:0] MODE_SHORT_DATE = 2'd1;
  localparam logic [1:0] MODE_LONG_DATE  = 2'd2;

  localparam logic [7:0] DP_BIT = 8'h80;

  localparam logic [7:0] SEG_DIGIT [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Time and date; year is kept both in binary and as four BCD digits
  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [13:0] year;
    logic [15:0] year_bcd;
    logic [3:0]  month;
    logic [4:0]  day;
  } cal_t;

  // Tens digit of a value below 64: v*13 >> 7 is exact over that range
  function automatic logic [3:0] tens_of(logic [5:0] v);
    logic [9:0] prod;
    prod = 10'(v) * 10'd13;
    return {1'b0, prod[9:7]};
  endfunction

  function automatic logic [3:0] ones_of(logic [5:0] v);
    logic [5:0] base;
    base = 6'(tens_of(v)) * 6'd10;
    return 4'(v - base);
  endfunction

  function automatic logic [7:0] seg_of(logic [3:0] d, logic dp);
    logic [3:0] idx;
    idx = (d > 4'd9) ? d - 4'd10 : d;
    return SEG_DIGIT[idx] | (dp ? DP_BIT : 8'h00);
  endfunction

endpackage

/* hdl/ccsd_calendar.sv */
// One-second advance of time and date with month lengths and the leap rule.
module ccsd_calendar (
  input  ccsd_pkg::cal_t cal,
  input  logic           step,
  output ccsd_pkg::cal_t cal_next
);
  import ccsd_pkg::*;

  logic [3:0] yd0, yd1, yd2, yd3;
  logic       last_two_zero, leap;
  logic [1:0] low_mod4, hund_mod4;
  logic [4:0] month_days;
  logic [3:0] month_idx;
  logic [5:0] second_inc, minute_inc, day_inc;
  logic [4:0] hour_inc, month_inc;
  logic [3:0] yd0_n, yd1_n, yd2_n, yd3_n;

  assign yd0 = cal.year_bcd[3:0];
  assign yd1 = cal.year_bcd[7:4];
  assign yd2 = cal.year_bcd[11:8];
  assign yd3 = cal.year_bcd[15:12];

  // 10t + o is 2t + o modulo 4
  assign low_mod4      = 2'({yd1[0], 1'b0} + yd0[1:0]);
  assign hund_mod4     = 2'({yd3[0], 1'b0} + yd2[1:0]);
  assign last_two_zero = (yd1 == 4'd0) && (yd0 == 4'd0);
  assign leap = ((low_mod4 == 2'd0) && !last_two_zero) ||
                (last_two_zero && (hund_mod4 == 2'd0));

  assign month_idx = cal.month - 4'd1;

  always_comb begin
    if (cal.month == 4'd2 && leap) begin
      month_days = 5'd29;
    end else if (cal.month < 4'd1 || cal.month > 4'd12) begin
      month_days = 5'd31;
    end else begin
      month_days = MONTH_LEN[month_idx];
    end
  end

  assign second_inc = cal.second + 6'd1;
  assign minute_inc = cal.minute + 6'd1;
  assign hour_inc   = cal.hour + 5'd1;
  assign day_inc    = {1'b0, cal.day} + 6'd1;
  assign month_inc  = {1'b0, cal.month} + 5'd1;

  // BCD year increment
  always_comb begin
    yd0_n = yd0;
    yd1_n = yd1;
    yd2_n = yd2;
    yd3_n = yd3;
    if (yd0 < 4'd9) begin
      yd0_n = yd0 + 4'd1;
    end else begin
      yd0_n = 4'd0;
      if (yd1 < 4'd9) begin
        yd1_n = yd1 + 4'd1;
      end else begin
        yd1_n = 4'd0;
        if (yd2 < 4'd9) begin
          yd2_n = yd2 + 4'd1;
        end else begin
          yd2_n = 4'd0;
          yd3_n = (yd3 < 4'd9) ? yd3 + 4'd1 : 4'd0;
        end
      end
    end
  end

  always_comb begin
    cal_next = cal;
    if (step) begin
      if (second_inc < 6'd60) begin
        cal_next.second = second_inc;
      end else begin
        cal_next.second = 6'd0;
        if (minute_inc < 6'd60) begin
          cal_next.minute = minute_inc;
        end else begin
          cal_next.minute = 6'd0;
          if (hour_inc < 5'd24) begin
            cal_next.hour = hour_inc;
          end else begin
            cal_next.hour = 5'd0;
            if (day_inc <= {1'b0, month_days}) begin
              cal_next.day = day_inc[4:0];
            end else begin
              cal_next.day = 5'd1;
              if (month_inc <= 5'd12) begin
                cal_next.month = month_inc[3:0];
              end else begin
                cal_next.month = 4'd1;
                if (cal.year >= 14'd9999) begin
                  cal_next.year     = 14'd0;
                  cal_next.year_bcd = 16'h0000;
                end else begin
                  cal_next.year     = cal.year + 14'd1;
                  cal_next.year_bcd = {yd3_n, yd2_n, yd1_n, yd0_n};
                end
              end
            end
          end
        end
      end
    end
  end

endmodule

/* hdl/ccsd_render.sv */
// Seven-segment rendering of time or date into eight segment bytes.
module ccsd_render (
  input  ccsd_pkg::cal_t cal,
  input  logic [1:0]     mode,
  input  logic           enable,
  output logic [63:0]    segments
);
  import ccsd_pkg::*;

  logic [7:0] digit [8];
  logic [3:0] a_tens, a_ones, b_tens, b_ones, c_tens, c_ones;

  always_comb begin
    if (mode == MODE_SHORT_DATE) begin
      a_tens = cal.year_bcd[7:4];
      a_ones = cal.year_bcd[3:0];
      b_tens = tens_of({2'b00, cal.month});
      b_ones = ones_of({2'b00, cal.month});
      c_tens = tens_of({1'b0, cal.day});
      c_ones = ones_of({1'b0, cal.day});
    end else begin
      a_tens = tens_of({1'b0, cal.hour});
      a_ones = ones_of({1'b0, cal.hour});
      b_tens = tens_of(cal.minute);
      b_ones = ones_of(cal.minute);
      c_tens = tens_of(cal.second);
      c_ones = ones_of(cal.second);
    end
  end

  always_comb begin
    if (mode == MODE_LONG_DATE) begin
      digit[0] = seg_of(cal.year_bcd[15:12], 1'b0);
      digit[1] = seg_of(cal.year_bcd[11:8], 1'b0);
      digit[2] = seg_of(cal.year_bcd[7:4], 1'b0);
      digit[3] = seg_of(cal.year_bcd[3:0], 1'b1);
      digit[4] = seg_of(tens_of({2'b00, cal.month}), 1'b0);
      digit[5] = seg_of(ones_of({2'b00, cal.month}), 1'b0);
      digit[6] = seg_of(tens_of({1'b0, cal.day}), 1'b0);
      digit[7] = seg_of(ones_of({1'b0, cal.day}), 1'b0);
    end else begin
      digit[0] = seg_of(a_tens, 1'b0);
      digit[1] = seg_of(a_ones, 1'b1);
      digit[2] = seg_of(b_tens, 1'b0);
      digit[3] = seg_of(b_ones, 1'b1);
      digit[4] = seg_of(c_tens, 1'b0);
      digit[5] = seg_of(c_ones, 1'b0);
      digit[6] = 8'h00;
      digit[7] = 8'h00;
    end
  end

  always_comb begin
    segments = 64'd0;
    if (enable) begin
      for (int j = 0; j < 8; j++) begin
        segments[8*j +: 8] = digit[j];
      end
    end
  end

endmodule

/* hdl/calendar_clock_segment_display.sv */
// Calendar clock with key-selected display mode and seven-segment output.
// Each input transaction is one 10 ms tick carrying the mode key level and
// yields one output transaction with the rendered segment bytes, the mode and
// the time and date after that tick. A tick is held in an input register; the
// key, sub-second, calendar and rendering logic all run combinationally as it
// moves into the output register, so the block takes one tick per clock while
// the output is taken, and its result is valid from the output register. The
// output register stalls the input side only while its result is not taken.
// The year is also kept as BCD digits so the display needs no divider.
// Configuration writes are accepted on every cycle.
module calendar_clock_segment_display (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 key_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          segments,
  output logic [1:0]           display_mode,
  output logic [4:0]           hours,
  output logic [5:0]           minutes,
  output logic [5:0]           seconds,
  output logic [13:0]          year_count,
  output logic [3:0]           month_count,
  output logic [4:0]           day_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  ccsd_pkg::cfg_index_t cfg_index,
  input  ccsd_pkg::cfg_data_t  cfg_data
);
  import ccsd_pkg::*;

  // Configuration
  logic       display_enable;
  logic [6:0] ticks_per_second;
  logic [7:0] min_press_ticks;
  logic [7:0] max_press_ticks;

  // State
  cal_t       cal, cal_next;
  logic [1:0] mode, mode_next;
  logic       key_previous;
  logic [7:0] press_ticks, press_next, press_inc;
  logic [6:0] subsecond, subsecond_next;
  logic [7:0] sub_inc;
  logic [6:0] tps_eff;
  logic       second_step;

  // Input register
  logic key_q;
  logic key_q_valid;
  logic advance;

  logic [63:0] segments_next;

  assign cfg_ready = 1'b1;

  assign advance  = key_q_valid && (!out_valid || out_ready);
  assign in_ready = !key_q_valid || advance;

  // Key press timing
  assign press_inc = (press_ticks == 8'hff) ? 8'hff : press_ticks + 8'd1;

  always_comb begin
    press_next = press_ticks;
    mode_next  = mode;
    if (key_previous && !key_q) begin
      press_next = 8'd0;
    end else if (!key_previous) begin
      press_next = press_inc;
      if (key_q && press_inc > min_press_ticks && press_inc < max_press_ticks) begin
        mode_next = (mode >= MODE_LONG_DATE) ? MODE_TIME : mode + 2'd1;
      end
    end
  end

  // Sub-second count; zero ticks per second behaves as one
  assign tps_eff        = (ticks_per_second == 7'd0) ? 7'd1 : ticks_per_second;
  assign sub_inc        = {1'b0, subsecond} + 8'd1;
  assign second_step    = sub_inc >= {1'b0, tps_eff};
  assign subsecond_next = second_step ? 7'd0 : sub_inc[6:0];

  ccsd_calendar u_calendar (
    .cal      (cal),
    .step     (second_step),
    .cal_next (cal_next)
  );

  ccsd_render u_render (
    .cal      (cal_next),
    .mode     (mode_next),
    .enable   (display_enable),
    .segments (segments_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable   <= 1'b1;
      ticks_per_second <= 7'd100;
      min_press_ticks  <= 8'd2;
      max_press_ticks  <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DISPLAY_ENABLE:   display_enable   <= cfg_data[0];
        CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data[6:0];
        CFG_MIN_PRESS_TICKS:  min_press_ticks  <= cfg_data;
        CFG_MAX_PRESS_TICKS:  max_press_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      key_q_valid <= 1'b1;
    end else if (advance) begin
      key_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_q <= key_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.hour     <= 5'd12;
      cal.minute   <= 6'd34;
      cal.second   <= 6'd56;
      cal.year     <= 14'd2026;
      cal.year_bcd <= 16'h2026;
      cal.month    <= 4'd6;
      cal.day      <= 5'd8;
      mode         <= MODE_TIME;
      key_previous <= 1'b1;
      press_ticks  <= 8'd0;
      subsecond    <= 7'd0;
    end else if (advance) begin
      cal          <= cal_next;
      mode         <= mode_next;
      key_previous <= key_q;
      press_ticks  <= press_next;
      subsecond    <= subsecond_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (advance) begin
      segments     <= segments_next;
      display_mode <= mode_next;
      hours        <= cal_next.hour;
      minutes      <= cal_next.minute;
      seconds      <= cal_next.second;
      year_count   <= cal_next.year;
      month_count  <= cal_next.month;
      day_count    <= cal_next.day;
    end
  end

endmodule
